>>> rtl/ftacc_pkg.sv
// Shared widths, constants, register indexes and types for the fixed-timestep accumulator.
// Used by the sequencer, the top level and the port checker; depends on nothing.
`timescale 1ns / 1ps

package ftacc_pkg;

    localparam int STAMP_W            = 48;
    localparam int STAMP_BITS         = 48;
    localparam int PERIOD_W           = 20;
    localparam int STEPS_W            = 7;
    localparam int CLAMP_W            = 24;
    localparam int BACKLOG_W          = 22;
    localparam int ALPHA_W            = 16;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_DATA_W         = 24;
    localparam int BACKLOG_CAP_FACTOR = 4;

    localparam int ACC_W      = CLAMP_W + 1;
    localparam int CAP_W      = PERIOD_W + 5;
    localparam int DIV_CNT_W  = $clog2(ALPHA_W);

    localparam logic [STAMP_W-1:0] STAMP_MASK =
        (STAMP_BITS >= STAMP_W) ? {STAMP_W{1'b1}}
                                : ((STAMP_W'(1) << STAMP_BITS) - STAMP_W'(1));
    localparam logic [BACKLOG_W-1:0] BACKLOG_MAX = {BACKLOG_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP  = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RST = 20'd16667;
    localparam logic [STEPS_W-1:0]  STEPS_RST  = 7'd5;
    localparam logic [CLAMP_W-1:0]  CLAMP_RST  = 24'd250000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELTA,
        ST_ACCUM,
        ST_STEP,
        ST_CAP,
        ST_SAT,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic do_delta;
        logic do_accum;
        logic step_take;
        logic step_end;
        logic do_cap;
        logic do_sat;
        logic do_div;
        logic sel_div;
        logic load_out;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic ge;
        logic below_max;
        logic out_free;
    } stat_t;

endpackage

>>> rtl/ftacc_ctrl.sv
// Sequencer for the fixed-timestep accumulator: frame delta, step loop, cap and serial divide.
// Depends on ftacc_pkg for the state enum and the control and status structs.
`timescale 1ns / 1ps

module ftacc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  ftacc_pkg::stat_t stat,
    output ftacc_pkg::ctrl_t ctrl
);

    ftacc_pkg::state_t                     state_reg;
    ftacc_pkg::state_t                     state_next;
    logic [ftacc_pkg::DIV_CNT_W-1:0]       cnt_reg;
    logic [ftacc_pkg::DIV_CNT_W-1:0]       cnt_next;
    logic                                  div_last;
    logic                                  step_go;

    assign div_last = (cnt_reg == ftacc_pkg::DIV_CNT_W'(ftacc_pkg::ALPHA_W - 1));
    assign step_go  = stat.ge && stat.below_max;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ftacc_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ftacc_pkg::ST_IDLE:
            begin
                if (stat.in_valid)
                begin
                    state_next = ftacc_pkg::ST_DELTA;
                end
            end
            ftacc_pkg::ST_DELTA: state_next = ftacc_pkg::ST_ACCUM;
            ftacc_pkg::ST_ACCUM: state_next = ftacc_pkg::ST_STEP;
            ftacc_pkg::ST_STEP:
            begin
                if (!step_go)
                begin
                    state_next = ftacc_pkg::ST_CAP;
                end
            end
            ftacc_pkg::ST_CAP: state_next = ftacc_pkg::ST_SAT;
            ftacc_pkg::ST_SAT:
            begin
                cnt_next   = '0;
                state_next = ftacc_pkg::ST_DIV;
            end
            ftacc_pkg::ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (div_last)
                begin
                    state_next = ftacc_pkg::ST_DONE;
                end
            end
            ftacc_pkg::ST_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = ftacc_pkg::ST_IDLE;
                end
            end
            default: state_next = ftacc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        case (state_reg)
            ftacc_pkg::ST_IDLE:  ctrl.in_ready = 1'b1;
            ftacc_pkg::ST_DELTA: ctrl.do_delta = 1'b1;
            ftacc_pkg::ST_ACCUM: ctrl.do_accum = 1'b1;
            ftacc_pkg::ST_STEP:
            begin
                ctrl.step_take = step_go;
                ctrl.step_end  = !step_go;
            end
            ftacc_pkg::ST_CAP:   ctrl.do_cap = 1'b1;
            ftacc_pkg::ST_SAT:   ctrl.do_sat = 1'b1;
            ftacc_pkg::ST_DIV:
            begin
                ctrl.do_div  = 1'b1;
                ctrl.sel_div = 1'b1;
            end
            ftacc_pkg::ST_DONE:  ctrl.load_out = stat.out_free;
            default:             ctrl = '0;
        endcase
    end

endmodule

>>> rtl/fixed_timestep_accumulator_unit.sv
// Top level of the fixed-timestep accumulator: configuration registers, datapath and output word.
// Depends on ftacc_pkg and instantiates the sequencer ftacc_ctrl.
`timescale 1ns / 1ps

// Each input word is the start timestamp of one rendered frame in microseconds. The block
// works out the clamped frame time, adds it to the backlog, counts fixed steps, caps the
// backlog and returns one result word with the steps, spiral flag and interpolation alpha.
// Both channels use valid and ready; a word moves when both are high at a clock edge.
// Configuration is written through cfg_we, cfg_index and cfg_data; the user must write it
// only while the block is idle, which it does not enforce. An unknown index is ignored.
// A single subtract and compare unit does the step loop (up to 127 fixed steps), the
// saturation check and a 16-bit restoring divide, one step or one quotient bit per cycle,
// and the block takes no new word while that unit is busy.
// The result sits in an output register, so a new word is accepted while an earlier result
// still waits. If the receiver stalls and a second result is ready, the block holds it
// until the output register frees up.
// Reset returns the registers to their defaults, clears the backlog and marks no frame seen,
// so the first frame after reset has a frame time of zero.
module fixed_timestep_accumulator_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [ftacc_pkg::STAMP_W-1:0]       now_us,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ftacc_pkg::STEPS_W-1:0]       fixed_steps,
    output logic                                spiral,
    output logic [ftacc_pkg::ALPHA_W-1:0]       alpha_frac,
    output logic [ftacc_pkg::CLAMP_W-1:0]       frame_time_us,
    output logic [ftacc_pkg::BACKLOG_W-1:0]     backlog_us,
    input  logic                                cfg_we,
    input  logic [ftacc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ftacc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    ftacc_pkg::ctrl_t ctrl;
    ftacc_pkg::stat_t stat;

    logic [ftacc_pkg::PERIOD_W-1:0]  period_reg;
    logic [ftacc_pkg::STEPS_W-1:0]   max_steps_reg;
    logic [ftacc_pkg::CLAMP_W-1:0]   clamp_reg;

    logic [ftacc_pkg::STAMP_W-1:0]   now_reg;
    logic [ftacc_pkg::STAMP_W-1:0]   last_reg;
    logic                            started_reg;
    logic [ftacc_pkg::BACKLOG_W-1:0] backlog_reg;
    logic [ftacc_pkg::CLAMP_W-1:0]   ftime_reg;
    logic [ftacc_pkg::ACC_W-1:0]     acc_reg;
    logic [ftacc_pkg::ACC_W-1:0]     acc_next;
    logic [ftacc_pkg::STEPS_W-1:0]   steps_reg;
    logic                            spiral_reg;
    logic                            sat_reg;
    logic [ftacc_pkg::ALPHA_W-1:0]   quot_reg;
    logic                            out_valid_reg;
    logic                            out_valid_next;

    logic [ftacc_pkg::PERIOD_W-1:0]  period_eff;
    logic [ftacc_pkg::STAMP_W-1:0]   stamp_diff;
    logic                            stamp_fwd;
    logic [ftacc_pkg::CLAMP_W-1:0]   ftime_val;
    logic [ftacc_pkg::ACC_W-1:0]     acc_shift;
    logic [ftacc_pkg::ACC_W-1:0]     alu_a;
    logic [ftacc_pkg::ACC_W:0]       alu_diff;
    logic                            alu_ge;
    logic [ftacc_pkg::CAP_W-1:0]     cap_full;
    logic [ftacc_pkg::BACKLOG_W-1:0] cap_val;
    logic [ftacc_pkg::BACKLOG_W-1:0] acc_capped;

    assign period_eff = (period_reg == '0) ? ftacc_pkg::PERIOD_W'(1) : period_reg;

    // Frame delta: zero on the first frame and when the timestamp goes backwards, else clamped.
    assign stamp_diff = now_reg - last_reg;
    assign stamp_fwd  = started_reg && (now_reg >= last_reg);
    always_comb
    begin
        if (!stamp_fwd)
        begin
            ftime_val = '0;
        end
        else if (stamp_diff > ftacc_pkg::STAMP_W'(clamp_reg))
        begin
            ftime_val = clamp_reg;
        end
        else
        begin
            ftime_val = stamp_diff[ftacc_pkg::CLAMP_W-1:0];
        end
    end

    // The shared unit: one subtract of the period, its borrow giving the compare.
    assign acc_shift = {acc_reg[ftacc_pkg::ACC_W-2:0], 1'b0};
    assign alu_a     = ctrl.sel_div ? acc_shift : acc_reg;
    assign alu_diff  = {1'b0, alu_a} - (ftacc_pkg::ACC_W + 1)'(period_eff);
    assign alu_ge    = !alu_diff[ftacc_pkg::ACC_W];

    assign cap_full   = ftacc_pkg::CAP_W'(period_eff)
                        * ftacc_pkg::CAP_W'(ftacc_pkg::BACKLOG_CAP_FACTOR);
    assign cap_val    = (cap_full > ftacc_pkg::CAP_W'(ftacc_pkg::BACKLOG_MAX))
                        ? ftacc_pkg::BACKLOG_MAX : cap_full[ftacc_pkg::BACKLOG_W-1:0];
    assign acc_capped = (acc_reg > ftacc_pkg::ACC_W'(cap_val))
                        ? cap_val : acc_reg[ftacc_pkg::BACKLOG_W-1:0];

    assign stat.in_valid  = in_valid;
    assign stat.ge        = alu_ge;
    assign stat.below_max = (steps_reg < max_steps_reg);
    assign stat.out_free  = !out_valid_reg || out_ready;

    ftacc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg    <= ftacc_pkg::PERIOD_RST;
            max_steps_reg <= ftacc_pkg::STEPS_RST;
            clamp_reg     <= ftacc_pkg::CLAMP_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ftacc_pkg::REG_PERIOD: period_reg    <= cfg_data[ftacc_pkg::PERIOD_W-1:0];
                ftacc_pkg::REG_STEPS:  max_steps_reg <= cfg_data[ftacc_pkg::STEPS_W-1:0];
                ftacc_pkg::REG_CLAMP:  clamp_reg     <= cfg_data[ftacc_pkg::CLAMP_W-1:0];
                default:               period_reg    <= period_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= '0;
            started_reg   <= 1'b0;
            backlog_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (ctrl.do_delta)
            begin
                last_reg    <= now_reg;
                started_reg <= 1'b1;
            end
            if (ctrl.do_cap)
            begin
                backlog_reg <= acc_capped;
            end
        end
    end

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.do_accum)
        begin
            acc_next = ftacc_pkg::ACC_W'(backlog_reg) + ftacc_pkg::ACC_W'(ftime_reg);
        end
        else if (ctrl.step_take || (ctrl.do_div && alu_ge))
        begin
            acc_next = alu_diff[ftacc_pkg::ACC_W-1:0];
        end
        else if (ctrl.do_div)
        begin
            acc_next = acc_shift;
        end
        else if (ctrl.do_cap)
        begin
            acc_next = ftacc_pkg::ACC_W'(acc_capped);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (ctrl.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (in_valid && ctrl.in_ready)
        begin
            now_reg <= now_us & ftacc_pkg::STAMP_MASK;
        end
        if (ctrl.do_delta)
        begin
            ftime_reg <= ftime_val;
        end
        if (ctrl.do_accum)
        begin
            steps_reg <= '0;
        end
        else if (ctrl.step_take)
        begin
            steps_reg <= steps_reg + 1'b1;
        end
        if (ctrl.step_end)
        begin
            spiral_reg <= !stat.below_max && alu_ge;
        end
        if (ctrl.do_sat)
        begin
            sat_reg <= alu_ge;
        end
        if (ctrl.do_div)
        begin
            quot_reg <= {quot_reg[ftacc_pkg::ALPHA_W-2:0], alu_ge};
        end
        if (ctrl.load_out)
        begin
            fixed_steps   <= steps_reg;
            spiral        <= spiral_reg;
            alpha_frac    <= sat_reg ? {ftacc_pkg::ALPHA_W{1'b1}} : quot_reg;
            frame_time_us <= ftime_reg;
            backlog_us    <= backlog_reg;
        end
    end

    assign in_ready  = ctrl.in_ready;
    assign out_valid = out_valid_reg;

endmodule

>>> rtl/ftacc_check.sv
// Port-level checker for the fixed-timestep accumulator, attached to the top level by bind.
// Depends on ftacc_pkg for the field widths.
`timescale 1ns / 1ps

module ftacc_check (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            in_valid,
    input logic                            in_ready,
    input logic                            out_valid,
    input logic                            out_ready,
    input logic [ftacc_pkg::STEPS_W-1:0]   fixed_steps,
    input logic [ftacc_pkg::ALPHA_W-1:0]   alpha_frac,
    input logic [ftacc_pkg::BACKLOG_W-1:0] backlog_us
);

    // A stalled result word stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its steps, alpha and backlog fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(fixed_steps) && $stable(alpha_frac)
                                    && $stable(backlog_us))
        else $error("result word changed while stalled");

    // After taking a word the block is busy with it.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again straight after a word");

    // A result needs the whole sequence; out_valid never rises in the cycle after an input.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared one cycle after input");

endmodule

bind fixed_timestep_accumulator_unit ftacc_check u_ftacc_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .fixed_steps (fixed_steps),
    .alpha_frac  (alpha_frac),
    .backlog_us  (backlog_us)
);

>>> tb/tb.sv
// Self-checking testbench for fixed_timestep_accumulator_unit: drives frame timestamps under
// several register settings and checks every result word against a built-in predictor.
// Depends on ftacc_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module tb;

    localparam logic [ftacc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 200;
    localparam int REPORT_LIMIT = 40;

    typedef struct packed {
        logic [ftacc_pkg::STEPS_W-1:0]   steps;
        logic                            spiral_flag;
        logic [ftacc_pkg::ALPHA_W-1:0]   alpha;
        logic [ftacc_pkg::CLAMP_W-1:0]   frame_time;
        logic [ftacc_pkg::BACKLOG_W-1:0] backlog;
    } frame_result_t;

    logic                              clk = 1'b0;
    logic                              rst_n = 1'b0;
    logic                              in_valid = 1'b0;
    logic                              in_ready;
    logic [ftacc_pkg::STAMP_W-1:0]     now_us = '0;
    logic                              out_valid;
    logic                              out_ready = 1'b0;
    logic [ftacc_pkg::STEPS_W-1:0]     fixed_steps;
    logic                              spiral;
    logic [ftacc_pkg::ALPHA_W-1:0]     alpha_frac;
    logic [ftacc_pkg::CLAMP_W-1:0]     frame_time_us;
    logic [ftacc_pkg::BACKLOG_W-1:0]   backlog_us;
    logic                              cfg_we = 1'b0;
    logic [ftacc_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [ftacc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    logic [ftacc_pkg::PERIOD_W-1:0]    cur_period = ftacc_pkg::PERIOD_RST;
    logic [ftacc_pkg::STEPS_W-1:0]     cur_max_steps = ftacc_pkg::STEPS_RST;
    logic [ftacc_pkg::CLAMP_W-1:0]     cur_clamp = ftacc_pkg::CLAMP_RST;
    logic [ftacc_pkg::STAMP_W-1:0]     prev_stamp = '0;
    logic                              seen_frame = 1'b0;
    logic [ftacc_pkg::BACKLOG_W-1:0]   held_backlog = '0;

    logic [ftacc_pkg::STAMP_W-1:0]     frame_stamps[$];
    frame_result_t                     expected_frames[$];
    frame_result_t                     oldest_frame;

    int send_gap = 0;
    int recv_hold = 0;
    int quiet_cycles = 0;
    bit sender_calm = 1'b0;
    bit receiver_calm = 1'b0;
    int mismatches = 0;
    int words_sent = 0;
    int results_checked = 0;
    int spirals_seen = 0;
    int most_steps = 0;
    int settings_run = 1;

    fixed_timestep_accumulator_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .now_us        (now_us),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .fixed_steps   (fixed_steps),
        .spiral        (spiral),
        .alpha_frac    (alpha_frac),
        .frame_time_us (frame_time_us),
        .backlog_us    (backlog_us),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic frame_result_t advance_frame(
        input logic [ftacc_pkg::STAMP_W-1:0] stamp);
        logic [ftacc_pkg::STAMP_W-1:0] masked;
        longint unsigned               period;
        longint unsigned               elapsed;
        longint unsigned               acc;
        longint unsigned               cap;
        longint unsigned               ratio;
        int unsigned                   steps;
        frame_result_t                 res;
        masked = stamp & ftacc_pkg::STAMP_MASK;
        period = (cur_period == '0) ? 64'd1 : 64'(cur_period);
        elapsed = 64'd0;
        if (seen_frame && masked >= prev_stamp)
            elapsed = 64'(masked - prev_stamp);
        if (elapsed > 64'(cur_clamp))
            elapsed = 64'(cur_clamp);
        prev_stamp = masked;
        seen_frame = 1'b1;
        acc = 64'(held_backlog) + elapsed;
        steps = 0;
        while (acc >= period && steps < 32'(cur_max_steps))
        begin
            acc = acc - period;
            steps++;
        end
        res.spiral_flag = (steps >= 32'(cur_max_steps)) && (acc >= period);
        cap = period * 64'(ftacc_pkg::BACKLOG_CAP_FACTOR);
        if (cap > 64'(ftacc_pkg::BACKLOG_MAX))
            cap = 64'(ftacc_pkg::BACKLOG_MAX);
        if (acc > cap)
            acc = cap;
        held_backlog = acc[ftacc_pkg::BACKLOG_W-1:0];
        ratio = (acc << 16) / period;
        if (ratio > 64'({ftacc_pkg::ALPHA_W{1'b1}}))
            ratio = 64'({ftacc_pkg::ALPHA_W{1'b1}});
        res.steps = steps[ftacc_pkg::STEPS_W-1:0];
        res.alpha = ratio[ftacc_pkg::ALPHA_W-1:0];
        res.frame_time = elapsed[ftacc_pkg::CLAMP_W-1:0];
        res.backlog = acc[ftacc_pkg::BACKLOG_W-1:0];
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    // Mostly plausible frame intervals around the period, with some clamped jumps,
    // backward steps and arbitrary stamps mixed in.
    function automatic logic [ftacc_pkg::STAMP_W-1:0] next_stamp(
        input logic [ftacc_pkg::STAMP_W-1:0] prev,
        input longint unsigned               span,
        input longint unsigned               clamp);
        int              roll;
        longint unsigned delta;
        roll = $urandom_range(0, 99);
        if (roll < 68)
            delta = 64'($urandom_range(0, 32'(2 * span + span / 2)));
        else if (roll < 78)
            delta = 64'($urandom_range(0, 32'(span / 4)));
        else if (roll < 88)
            delta = 64'($urandom_range(32'(span), 32'(12 * span)));
        else if (roll < 94)
            delta = clamp + 64'($urandom_range(0, 32'(clamp)));
        else if (roll < 97)
        begin
            delta = {$urandom, $urandom} % (64'(prev) + 64'd1);
            return prev - ftacc_pkg::STAMP_W'(delta);
        end
        else
            return ftacc_pkg::STAMP_W'({$urandom, $urandom});
        return prev + ftacc_pkg::STAMP_W'(delta);
    endfunction

    task automatic queue_stamp(input logic [ftacc_pkg::STAMP_W-1:0] stamp);
        frame_stamps.insert(frame_stamps.size(), stamp);
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic drain_pipeline();
        while (frame_stamps.size() != 0 || in_valid || expected_frames.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [ftacc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ftacc_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            ftacc_pkg::REG_PERIOD: cur_period = data[ftacc_pkg::PERIOD_W-1:0];
            ftacc_pkg::REG_STEPS:  cur_max_steps = data[ftacc_pkg::STEPS_W-1:0];
            ftacc_pkg::REG_CLAMP:  cur_clamp = data[ftacc_pkg::CLAMP_W-1:0];
            default:               ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_setting(input logic [ftacc_pkg::CFG_DATA_W-1:0] period_data,
                               input logic [ftacc_pkg::CFG_DATA_W-1:0] steps_data,
                               input logic [ftacc_pkg::CFG_DATA_W-1:0] clamp_data,
                               input int count);
        logic [ftacc_pkg::STAMP_W-1:0] stamp;
        longint unsigned               span;
        drain_pipeline();
        write_reg(ftacc_pkg::REG_PERIOD, period_data);
        write_reg(ftacc_pkg::REG_STEPS, steps_data);
        write_reg(ftacc_pkg::REG_CLAMP, clamp_data);
        @(negedge clk);
        span = (cur_period == '0) ? 64'd1 : 64'(cur_period);
        stamp = ftacc_pkg::STAMP_W'({$urandom, $urandom});
        for (int i = 0; i < count; i++)
        begin
            stamp = next_stamp(stamp, span, 64'(cur_clamp));
            queue_stamp(stamp);
        end
        settings_run++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            now_us <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                expected_frames.insert(expected_frames.size(), advance_frame(now_us));
                words_sent++;
                if ($urandom_range(0, 39) == 0)
                    sender_calm = !sender_calm;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (frame_stamps.size() != 0)
                begin
                    in_valid <= 1'b1;
                    now_us <= frame_stamps.pop_front();
                    send_gap <= sender_calm ? 0 : pick_gap();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_hold <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result word with nothing expected, steps %0d backlog %0d",
                             $time, fixed_steps, backlog_us);
                end
                else
                begin
                    oldest_frame = expected_frames.pop_front();
                    check_field("fixed_steps", oldest_frame.steps, fixed_steps);
                    check_field("spiral", oldest_frame.spiral_flag, spiral);
                    check_field("alpha_frac", oldest_frame.alpha, alpha_frac);
                    check_field("frame_time_us", oldest_frame.frame_time, frame_time_us);
                    check_field("backlog_us", oldest_frame.backlog, backlog_us);
                    results_checked++;
                    if (oldest_frame.spiral_flag)
                        spirals_seen++;
                    if (32'(oldest_frame.steps) > most_steps)
                        most_steps = 32'(oldest_frame.steps);
                end
                if ($urandom_range(0, 39) == 0)
                    receiver_calm = !receiver_calm;
            end
            if (recv_hold != 0)
            begin
                out_ready <= 1'b0;
                recv_hold <= recv_hold - 1;
            end
            else if (!receiver_calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                recv_hold <= pick_gap();
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no word has moved for %0d cycles", $time, quiet_cycles);
            $display("FAIL fixed_timestep_accumulator_unit");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        queue_stamp(48'd0);
        queue_stamp(48'd16667);
        queue_stamp(48'd16667);
        queue_stamp(48'd10);
        queue_stamp(48'd1000010);
        queue_stamp(48'd2000010);
        queue_stamp(48'hFFFF_FFFF_FFFF);
        queue_stamp(48'd0);
        queue_stamp(48'd5000);
        queue_stamp(48'd13000);
        queue_stamp(48'd29667);
        queue_stamp(48'd33334);
        queue_stamp(48'h8000_0000_0000);
        queue_stamp(48'h8000_0000_4119);
        queue_stamp(48'h7FFF_FFFF_FFFF);
        queue_stamp(48'h5555_5555_5555);
        queue_stamp(48'hAAAA_AAAA_AAAA);
        queue_stamp(48'hAAAA_AAAA_AAAA + 48'd16000);

        run_setting(24'd1000, 24'd1, 24'd1000, 120);
        run_setting(24'd1000000, 24'd64, 24'd10000000, 120);
        run_setting(24'd0, 24'd3, 24'd0, 30);
        run_setting(24'h0F_FFFF, 24'h7F, 24'hFF_FFFF, 120);
        drain_pipeline();
        write_reg(REG_UNUSED, 24'hFF_FFFF);
        run_setting(24'd1, 24'd127, 24'hFF_FFFF, 100);
        run_setting(24'd0, 24'd127, 24'd200, 40);
        run_setting(24'd16667, 24'd0, 24'd250000, 40);
        for (int p = 0; p < 8; p++)
        begin
            logic [ftacc_pkg::CFG_DATA_W-1:0] pdata;
            logic [ftacc_pkg::CFG_DATA_W-1:0] sdata;
            logic [ftacc_pkg::CFG_DATA_W-1:0] cdata;
            pdata = ftacc_pkg::CFG_DATA_W'($urandom);
            sdata = ftacc_pkg::CFG_DATA_W'($urandom);
            pdata[ftacc_pkg::PERIOD_W-1:0] = ($urandom_range(0, 1) == 0)
                ? ftacc_pkg::PERIOD_W'($urandom_range(1000, 20000))
                : ftacc_pkg::PERIOD_W'($urandom_range(1000, 1000000));
            sdata[ftacc_pkg::STEPS_W-1:0] = ftacc_pkg::STEPS_W'($urandom_range(1, 64));
            cdata = ftacc_pkg::CFG_DATA_W'($urandom_range(1000, 10000000));
            run_setting(pdata, sdata, cdata, 140);
        end

        drain_pipeline();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d frame stamps across %0d register settings; %0d results checked.",
                 words_sent, settings_run, results_checked);
        $display("Covered %0d spiral frames, up to %0d steps per frame, zero and extreme settings.",
                 spirals_seen, most_steps);
        if (mismatches == 0 && expected_frames.size() == 0)
            $display("PASS fixed_timestep_accumulator_unit");
        else
            $display("FAIL fixed_timestep_accumulator_unit");
        $finish;
    end

endmodule

>>> files.f
rtl/ftacc_pkg.sv
rtl/ftacc_ctrl.sv
rtl/fixed_timestep_accumulator_unit.sv
rtl/ftacc_check.sv
tb/tb.sv
